// File: rtl/core/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and constants of the golden-angle sphere point generator.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Q.30 unit value
  localparam logic [30:0] ONE30 = 31'h4000_0000;

  // the golden angle as a fraction of one turn, Q0.32
  localparam logic [31:0] GOLDEN_TURN = 32'h61C8_8647;

  // square root operand width and bit steps
  localparam int SQRT_IN_W  = 61;
  localparam int SQRT_STEPS = 31;

  // sine pipeline depth
  localparam int SINE_LAT = 7;

  // odd Taylor coefficients of sin(pi/2*x), Horner order (degree 11 first)
  localparam logic [31:0] SIN_COEF [6] = '{
    32'd3864, 32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT = 3'd0,
    REG_RADIUS      = 3'd1,
    REG_LAT_MIN     = 3'd2,
    REG_LAT_MAX     = 3'd3,
    REG_LON_MIN     = 3'd4,
    REG_LON_MAX     = 3'd5
  } fsp_reg_e;

  typedef struct packed {
    logic [15:0] point_count;
    logic [30:0] radius;
    logic [15:0] lat_min;
    logic [15:0] lat_max;
    logic [15:0] lon_min;
    logic [15:0] lon_max;
  } fsp_cfg_t;

endpackage

// File: rtl/core/fsp_in_if.sv
// ----------------------------------------------------------------------------
// fsp_in_if
// Point request channel: index and sphere centre.
// ----------------------------------------------------------------------------
interface fsp_in_if #(
  parameter int INDEX_WIDTH = 16,
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [INDEX_WIDTH-1:0]        point_index;
  logic signed [COORD_WIDTH-1:0] centre_x;
  logic signed [COORD_WIDTH-1:0] centre_y;
  logic signed [COORD_WIDTH-1:0] centre_z;

  modport source (output valid, point_index, centre_x, centre_y, centre_z, input ready);
  modport sink   (input valid, point_index, centre_x, centre_y, centre_z, output ready);
endinterface

// File: rtl/core/fsp_out_if.sv
// ----------------------------------------------------------------------------
// fsp_out_if
// Point result channel: position and clamp flag.
// ----------------------------------------------------------------------------
interface fsp_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic                          clamped;

  modport source (output valid, pos_x, pos_y, pos_z, clamped, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, clamped, output ready);
endinterface

// File: rtl/core/fsp_delay.sv
// ----------------------------------------------------------------------------
// fsp_delay
// Enabled shift line that keeps side data aligned with the arithmetic units.
// ----------------------------------------------------------------------------
module fsp_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];
endmodule

// File: rtl/core/fsp_div.sv
// ----------------------------------------------------------------------------
// fsp_div
// Pipelined restoring divider, one quotient bit per stage, 16-bit divisor.
// ----------------------------------------------------------------------------
module fsp_div #(
  parameter int NUM_W = 47
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [15:0]      den_i,
  output logic [NUM_W-1:0] quo_o
);
  localparam int RW = 17;

  logic [NUM_W-1:0] num_q [NUM_W];
  logic [NUM_W-1:0] quo_q [NUM_W];
  logic [RW-1:0]    rem_q [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [NUM_W-1:0] n;
    logic [NUM_W-1:0] qv;
    logic [RW-1:0]    r;
    logic [RW-1:0]    t;
    logic             ge;

    if (i == 0) begin : g_first
      assign n  = num_i;
      assign qv = '0;
      assign r  = '0;
    end else begin : g_next
      assign n  = num_q[i-1];
      assign qv = quo_q[i-1];
      assign r  = rem_q[i-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign t  = {r[RW-2:0], n[NUM_W-1]};
    assign ge = (t >= {1'b0, den_i});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[i] <= {n[NUM_W-2:0], 1'b0};
        quo_q[i] <= {qv[NUM_W-2:0], ge};
        rem_q[i] <= ge ? (t - {1'b0, den_i}) : t;
      end
    end
  end

  assign quo_o = quo_q[NUM_W-1];
endmodule

// File: rtl/core/fsp_isqrt.sv
// ----------------------------------------------------------------------------
// fsp_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module fsp_isqrt
  import fsp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [SQRT_IN_W-1:0] rad_i,
  output logic [30:0]          root_o
);
  logic [SQRT_IN_W-1:0] v_q [SQRT_STEPS];
  logic [SQRT_IN_W-1:0] r_q [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
    localparam logic [SQRT_IN_W-1:0] BIT = SQRT_IN_W'(1) << (SQRT_IN_W - 1 - 2 * i);
    logic [SQRT_IN_W-1:0] v;
    logic [SQRT_IN_W-1:0] r;
    logic [SQRT_IN_W:0]   trial;
    logic                 fits;

    if (i == 0) begin : g_first
      assign v = rad_i;
      assign r = '0;
    end else begin : g_next
      assign v = v_q[i-1];
      assign r = r_q[i-1];
    end

    assign trial = {1'b0, r} + {1'b0, BIT};
    assign fits  = ({1'b0, v} >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[i] <= fits ? (v - trial[SQRT_IN_W-1:0]) : v;
        r_q[i] <= fits ? ((r >> 1) + BIT) : (r >> 1);
      end
    end
  end

  assign root_o = r_q[SQRT_STEPS-1][30:0];
endmodule

// File: rtl/core/fsp_sine.sv
// ----------------------------------------------------------------------------
// fsp_sine
// Pipelined sine of a Q0.32 turn: quadrant fold, Horner polynomial in Q.30.
// ----------------------------------------------------------------------------
module fsp_sine
  import fsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] angle_i,
  output logic [30:0] mag_o,
  output logic        neg_o
);
  localparam int NSTG = SINE_LAT - 1;

  logic [30:0] x_q   [NSTG];
  logic [30:0] x2_q  [NSTG];
  logic [31:0] p_q   [NSTG];
  logic        neg_q [NSTG];
  logic [30:0] mag_q;
  logic        sgn_q;

  logic [30:0] x0;
  logic [61:0] xx;
  logic [62:0] pf;
  logic [32:0] pv;

  // mirror odd quadrants
  assign x0 = angle_i[30] ? (ONE30 - {1'b0, angle_i[29:0]}) : {1'b0, angle_i[29:0]};
  assign xx = x0 * x0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= x0;
      x2_q[0]  <= xx[60:30];
      p_q[0]   <= SIN_COEF[0];
      neg_q[0] <= angle_i[31];
    end
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_horner
    logic [62:0] prod;
    assign prod = p_q[k-1] * x2_q[k-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]   <= x_q[k-1];
        x2_q[k]  <= x2_q[k-1];
        p_q[k]   <= SIN_COEF[k] - prod[61:30];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  assign pf = p_q[NSTG-1] * x_q[NSTG-1];
  assign pv = pf[62:30];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= (pv > {2'b0, ONE30}) ? ONE30 : pv[30:0];
      sgn_q <= neg_q[NSTG-1];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = sgn_q;
endmodule

// File: rtl/core/fibonacci_sphere_point_generator.sv
// ----------------------------------------------------------------------------
// fibonacci_sphere_point_generator
// Streams golden-angle sphere points: latitude divider then ring square root
// beside the sine/cosine pipelines, then scale by radius and offset.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  in_i    | in  | valid/ready | point_index, centre_x/y/z
//  out_o   | out | valid/ready | pos_x/y/z, clamped
//  cfg     | in  | cfg_we_i    | cfg_idx_i, cfg_wdata_i
//
//  One point per cycle unless the output stalls; the longest path is the
//  one-bit-per-stage latitude divider (INDEX_WIDTH + 31 stages) followed by
//  the 31-stage square root.
//  Reset clears the valid bits and loads the register defaults.
//  A stall at the output freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module fibonacci_sphere_point_generator
  import fsp_pkg::*;
#(
  parameter int INDEX_WIDTH = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  fsp_in_if.sink                in_i,
  fsp_out_if.source             out_o
);
  localparam int NUM_W    = INDEX_WIDTH + 31;
  localparam int LAT      = NUM_W + 37;
  localparam int RING_STG = NUM_W + 34;
  localparam int SW       = ((COORD_WIDTH > 33) ? COORD_WIDTH : 33) + 1;
  localparam logic signed [SW-1:0] HI = {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] LO = ~HI;

  // configuration
  fsp_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.point_count <= 16'd1;
      cfg_q.radius      <= 31'd65536;
      cfg_q.lat_min     <= 16'd0;
      cfg_q.lat_max     <= 16'd32768;
      cfg_q.lon_min     <= 16'd0;
      cfg_q.lon_max     <= 16'd32768;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POINT_COUNT: cfg_q.point_count <= cfg_wdata_i[15:0];
        REG_RADIUS:      cfg_q.radius      <= cfg_wdata_i;
        REG_LAT_MIN:     cfg_q.lat_min     <= cfg_wdata_i[15:0];
        REG_LAT_MAX:     cfg_q.lat_max     <= cfg_wdata_i[15:0];
        REG_LON_MIN:     cfg_q.lon_min     <= cfg_wdata_i[15:0];
        REG_LON_MAX:     cfg_q.lon_max     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  logic               use_div;
  logic [15:0]        den;
  logic signed [16:0] lat_diff;
  logic [15:0]        lat_abs;
  logic signed [16:0] lon_span;
  logic               full_win;

  assign use_div  = (cfg_q.point_count > 16'd1);
  assign den      = cfg_q.point_count - 16'd1;
  assign lat_diff = $signed({1'b0, cfg_q.lat_max}) - $signed({1'b0, cfg_q.lat_min});
  assign lat_abs  = lat_diff[16] ? 16'(-lat_diff) : lat_diff[15:0];
  assign lon_span = $signed({1'b0, cfg_q.lon_max}) - $signed({1'b0, cfg_q.lon_min});
  assign full_win = (cfg_q.lon_min == 16'd0) && (cfg_q.lon_max == 16'd32768);

  // pipeline control
  logic           en;
  logic           acc;
  logic [LAT-1:0] valid_q;

  assign en       = !valid_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;
  assign acc      = in_i.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAT-2:0], acc};
    end
  end

  // stage 1: latitude numerator and raw azimuth
  logic [INDEX_WIDTH+15:0] lat_prod;
  logic [INDEX_WIDTH+31:0] az_prod;
  logic [NUM_W-1:0]        mag_q;
  logic [31:0]             a1_q;

  assign lat_prod = in_i.point_index * lat_abs;
  assign az_prod  = in_i.point_index * GOLDEN_TURN;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= {lat_prod, 15'd0};
      a1_q  <= az_prod[31:0];
    end
  end

  // stages 2-3: longitude window remap
  logic signed [49:0] pa_q;
  logic [31:0]        a2s_q;
  logic [31:0]        a3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q  <= $signed({1'b0, a1_q}) * lon_span;
      a2s_q <= a1_q;
      a3_q  <= full_win ? a2s_q : ({cfg_q.lon_min[14:0], 17'd0} + pa_q[46:15]);
    end
  end

  logic [31:0] ang_d;

  fsp_delay #(.W(32), .DEPTH(NUM_W + 24)) u_ang_dly (
    .clk_i (clk_i), .en_i (en), .d_i (a3_q), .q_o (ang_d)
  );

  logic [30:0] sin_mag;
  logic        sin_neg;
  logic [30:0] cos_mag;
  logic        cos_neg;

  fsp_sine u_sin (
    .clk_i (clk_i), .en_i (en), .angle_i (ang_d), .mag_o (sin_mag), .neg_o (sin_neg)
  );

  fsp_sine u_cos (
    .clk_i (clk_i), .en_i (en), .angle_i (ang_d + 32'h4000_0000),
    .mag_o (cos_mag), .neg_o (cos_neg)
  );

  // latitude divider
  logic [NUM_W-1:0] quo;

  fsp_div #(.NUM_W(NUM_W)) u_div (
    .clk_i (clk_i), .en_i (en), .num_i (mag_q), .den_i (den), .quo_o (quo)
  );

  // z stage: a quotient this large clamps z whichever its sign
  logic [31:0]        q_sat;
  logic signed [33:0] u_lat;
  logic signed [34:0] z_raw;
  logic signed [31:0] z_q;
  logic               zflag_q;

  always_comb begin
    if (!use_div) begin
      q_sat = '0;
    end else if (|quo[NUM_W-1:31]) begin
      q_sat = 32'h8000_0000;
    end else begin
      q_sat = {1'b0, quo[30:0]};
    end
    u_lat = lat_diff[16] ? ($signed({3'b0, cfg_q.lat_min, 15'd0}) - $signed({2'b0, q_sat}))
                         : ($signed({3'b0, cfg_q.lat_min, 15'd0}) + $signed({2'b0, q_sat}));
    z_raw = $signed({u_lat, 1'b0}) - $signed({4'b0, ONE30});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      priority if (z_raw > $signed({4'b0, ONE30})) begin
        z_q     <= $signed({1'b0, ONE30});
        zflag_q <= 1'b1;
      end else if (z_raw < -$signed({4'b0, ONE30})) begin
        z_q     <= -$signed({1'b0, ONE30});
        zflag_q <= 1'b1;
      end else begin
        z_q     <= z_raw[31:0];
        zflag_q <= 1'b0;
      end
    end
  end

  // ring operand
  logic [30:0]          zm;
  logic [61:0]          zsq;
  logic [SQRT_IN_W-1:0] rad_q;

  assign zm  = z_q[31] ? 31'(-z_q) : z_q[30:0];
  assign zsq = zm * zm;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= (SQRT_IN_W'(1) << 60) - zsq[SQRT_IN_W-1:0];
    end
  end

  logic [30:0] ring;

  fsp_isqrt u_sqrt (
    .clk_i (clk_i), .en_i (en), .rad_i (rad_q), .root_o (ring)
  );

  logic [32:0] zd;

  fsp_delay #(.W(33), .DEPTH(33)) u_z_dly (
    .clk_i (clk_i), .en_i (en), .d_i ({zflag_q, z_q}), .q_o (zd)
  );

  // unit vector stage
  logic [61:0] sx_prod;
  logic [61:0] sy_prod;
  logic [30:0] ux_q;
  logic [30:0] uy_q;
  logic        uxn_q;
  logic        uyn_q;

  assign sx_prod = sin_mag * ring;
  assign sy_prod = cos_mag * ring;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q  <= sx_prod[60:30];
      uy_q  <= sy_prod[60:30];
      uxn_q <= sin_neg;
      uyn_q <= cos_neg;
    end
  end

  // radius scaling stage
  logic [30:0] uz_mag;
  logic [61:0] px_prod;
  logic [61:0] py_prod;
  logic [61:0] pz_prod;
  logic [31:0] mx_q;
  logic [31:0] my_q;
  logic [31:0] mz_q;
  logic        mxn_q;
  logic        myn_q;
  logic        mzn_q;
  logic        flag_q;

  assign uz_mag  = zd[31] ? 31'(-$signed(zd[31:0])) : zd[30:0];
  assign px_prod = ux_q * cfg_q.radius;
  assign py_prod = uy_q * cfg_q.radius;
  assign pz_prod = uz_mag * cfg_q.radius;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q   <= px_prod[61:30];
      my_q   <= py_prod[61:30];
      mz_q   <= pz_prod[61:30];
      mxn_q  <= uxn_q;
      myn_q  <= uyn_q;
      mzn_q  <= zd[31];
      flag_q <= zd[32];
    end
  end

  // output stage: offset by centre and saturate
  logic [3*COORD_WIDTH-1:0] cen_d;

  fsp_delay #(.W(3*COORD_WIDTH), .DEPTH(NUM_W + 36)) u_cen_dly (
    .clk_i (clk_i), .en_i (en),
    .d_i   ({in_i.centre_x, in_i.centre_y, in_i.centre_z}),
    .q_o   (cen_d)
  );

  function automatic logic [COORD_WIDTH:0] sat_add(
    input logic [COORD_WIDTH-1:0] cen,
    input logic [31:0]            mag,
    input logic                   neg
  );
    logic signed [SW-1:0] ce;
    logic signed [SW-1:0] me;
    logic signed [SW-1:0] sum;
    ce  = SW'($signed(cen));
    me  = $signed(SW'(mag));
    sum = neg ? (ce - me) : (ce + me);
    priority if (sum > HI) begin
      sat_add = {1'b1, HI[COORD_WIDTH-1:0]};
    end else if (sum < LO) begin
      sat_add = {1'b1, LO[COORD_WIDTH-1:0]};
    end else begin
      sat_add = {1'b0, sum[COORD_WIDTH-1:0]};
    end
  endfunction

  logic [COORD_WIDTH:0] rx;
  logic [COORD_WIDTH:0] ry;
  logic [COORD_WIDTH:0] rz;

  assign rx = sat_add(cen_d[3*COORD_WIDTH-1:2*COORD_WIDTH], mx_q, mxn_q);
  assign ry = sat_add(cen_d[2*COORD_WIDTH-1:COORD_WIDTH], my_q, myn_q);
  assign rz = sat_add(cen_d[COORD_WIDTH-1:0], mz_q, mzn_q);

  logic signed [COORD_WIDTH-1:0] pos_x_q;
  logic signed [COORD_WIDTH-1:0] pos_y_q;
  logic signed [COORD_WIDTH-1:0] pos_z_q;
  logic                          clamped_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_x_q   <= rx[COORD_WIDTH-1:0];
      pos_y_q   <= ry[COORD_WIDTH-1:0];
      pos_z_q   <= rz[COORD_WIDTH-1:0];
      clamped_q <= flag_q | rx[COORD_WIDTH] | ry[COORD_WIDTH] | rz[COORD_WIDTH];
    end
  end

  assign out_o.valid   = valid_q[LAT-1];
  assign out_o.pos_x   = pos_x_q;
  assign out_o.pos_y   = pos_y_q;
  assign out_o.pos_z   = pos_z_q;
  assign out_o.clamped = clamped_q;

  // assertions
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> $stable(valid_q))
    else $error("pipeline moved during output stall");

  a_ring_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[RING_STG-1] |-> (ring <= ONE30))
    else $error("ring radius above one");

  a_sine_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[RING_STG-1] |-> ((sin_mag <= ONE30) && (cos_mag <= ONE30)))
    else $error("sine magnitude above one");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams point requests through the sphere point generator under several
// register settings, with random stalls on both channels, and checks every
// position and clamp flag against an in-bench integer model of the block.
// ----------------------------------------------------------------------------

typedef struct {
  logic [15:0]        idx;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cz;
} point_req_t;

typedef struct {
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  logic               clamped;
} point_pos_t;

class point_scoreboard;
  localparam longint ONE = 64'sd1 << 30;

  logic [15:0] count, lat_lo, lat_hi, lon_lo, lon_hi;
  logic [30:0] rad;
  point_pos_t  expected_q[$];
  int          errors;
  int          checked;
  int          clamp_seen;

  function new();
    count = 1; rad = 31'd65536; lat_lo = 0; lat_hi = 16'd32768;
    lon_lo = 0; lon_hi = 16'd32768; errors = 0; checked = 0; clamp_seen = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [30:0] val);
    case (idx)
      fsp_pkg::REG_POINT_COUNT: count  = val[15:0];
      fsp_pkg::REG_RADIUS:      rad    = val;
      fsp_pkg::REG_LAT_MIN:     lat_lo = val[15:0];
      fsp_pkg::REG_LAT_MAX:     lat_hi = val[15:0];
      fsp_pkg::REG_LON_MIN:     lon_lo = val[15:0];
      fsp_pkg::REG_LON_MAX:     lon_hi = val[15:0];
      default: ;
    endcase
  endfunction

  function longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function longint unsigned quarter_sine(longint unsigned x);
    longint unsigned x2, p;
    x2 = (x * x) >> 30;
    p = 64'd3864;
    p = 64'd172272 - ((p * x2) >> 30);
    p = 64'd5026995 - ((p * x2) >> 30);
    p = 64'd85569306 - ((p * x2) >> 30);
    p = 64'd693598668 - ((p * x2) >> 30);
    p = 64'd1686629713 - ((p * x2) >> 30);
    p = (p * x) >> 30;
    return (p > 64'd1073741824) ? 64'd1073741824 : p;
  endfunction

  function longint sine_turn(logic [31:0] a);
    longint unsigned x;
    longint s;
    x = {34'd0, a[29:0]};
    if (a[30]) x = 64'd1073741824 - x;
    s = longint'(quarter_sine(x));
    return a[31] ? -s : s;
  endfunction

  function longint mul_q30(longint a, longint unsigned b);
    longint unsigned mag;
    longint r;
    mag = (a < 0) ? longint'(-a) : a;
    r = longint'((mag * b) >> 30);
    return (a < 0) ? -r : r;
  endfunction

  function logic [31:0] place(longint c, longint u, ref bit flag);
    longint v;
    v = c + mul_q30(u, {33'd0, rad});
    if (v > 64'sd2147483647) begin v = 64'sd2147483647; flag = 1; end
    if (v < -64'sd2147483648) begin v = -64'sd2147483648; flag = 1; end
    return v[31:0];
  endfunction

  function point_pos_t compute_position(point_req_t r);
    point_pos_t      res;
    bit              flag;
    longint          u, z, diff, q, span, p, f, sn, cs;
    longint unsigned den, mag, zm, ring;
    logic [31:0]     a;
    flag = 0;
    u = longint'(lat_lo) <<< 15;
    if (count > 1) begin
      diff = longint'(lat_hi) - longint'(lat_lo);
      den  = count - 1;
      mag  = (longint'(r.idx) * ((diff < 0) ? -diff : diff)) << 15;
      q    = longint'(mag / den);
      u    = u + ((diff < 0) ? -q : q);
    end
    z = 2 * u - ONE;
    if (z > ONE) begin z = ONE; flag = 1; end
    if (z < -ONE) begin z = -ONE; flag = 1; end
    zm = (z < 0) ? -z : z;
    ring = root_floor((64'd1 << 60) - zm * zm);
    a = 32'(longint'(r.idx) * 64'h61C8_8647);
    if (lon_lo != 0 || lon_hi != 16'd32768) begin
      span = longint'(lon_hi) - longint'(lon_lo);
      p    = longint'(a) * span;
      f    = (p >= 0) ? (p >>> 15) : -longint'((longint'(-p) + 64'd32767) >> 15);
      a    = 32'((longint'(lon_lo) <<< 17) + f);
    end
    sn = mul_q30(sine_turn(a), ring);
    cs = mul_q30(sine_turn(a + 32'h4000_0000), ring);
    res.x = place(longint'(r.cx), sn, flag);
    res.y = place(longint'(r.cy), cs, flag);
    res.z = place(longint'(r.cz), z, flag);
    res.clamped = flag;
    return res;
  endfunction

  function void note_request(point_req_t r);
    expected_q.push_back(compute_position(r));
  endfunction

  function void check_position(point_pos_t got);
    point_pos_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result x=%h y=%h z=%h c=%b", $time,
               got.x, got.y, got.z, got.clamped);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    checked++;
    if (got.clamped) clamp_seen++;
    if (got.x !== want.x) begin
      $display("%0t: pos_x expected %h actual %h", $time, want.x, got.x); errors++;
    end
    if (got.y !== want.y) begin
      $display("%0t: pos_y expected %h actual %h", $time, want.y, got.y); errors++;
    end
    if (got.z !== want.z) begin
      $display("%0t: pos_z expected %h actual %h", $time, want.z, got.z); errors++;
    end
    if (got.clamped !== want.clamped) begin
      $display("%0t: clamped expected %b actual %b", $time, want.clamped, got.clamped);
      errors++;
    end
  endfunction
endclass

module tb;
  import fsp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 3000;
  localparam int NUM_ITEMS    = 1650;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  cfg_we_i = 0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  fsp_in_if  #(.INDEX_WIDTH(16), .COORD_WIDTH(32)) in_ch ();
  fsp_out_if #(.COORD_WIDTH(32)) out_ch ();

  fibonacci_sphere_point_generator #(.INDEX_WIDTH(16), .COORD_WIDTH(32)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  point_scoreboard sb = new();
  bit   steady;      // no idling on either side
  int   sink_wait;
  int   quiet_cycles;
  int   sent;
  point_pos_t got;

  always #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 0; in_ch.point_index = '0;
    in_ch.centre_x = '0; in_ch.centre_y = '0; in_ch.centre_z = '0;
    out_ch.ready = 0;
  end

  // result side: check each transfer, draw a stall per item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.x = out_ch.pos_x; got.y = out_ch.pos_y;
        got.z = out_ch.pos_z; got.clamped = out_ch.clamped;
        sb.check_position(got);
        sink_wait = steady ? 0 : $urandom_range(0, 4);
        out_ch.ready <= (sink_wait == 0);
      end else if (sink_wait > 0) begin
        sink_wait--;
        out_ch.ready <= (sink_wait == 0);
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(int cnt, int rad, int la, int lb, int oa, int ob);
    write_reg(REG_POINT_COUNT, CFG_DATA_W'(cnt));
    write_reg(REG_RADIUS, CFG_DATA_W'(rad));
    write_reg(REG_LAT_MIN, CFG_DATA_W'(la));
    write_reg(REG_LAT_MAX, CFG_DATA_W'(lb));
    write_reg(REG_LON_MIN, CFG_DATA_W'(oa));
    write_reg(REG_LON_MAX, CFG_DATA_W'(ob));
  endtask

  task automatic send_point(point_req_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1; in_ch.point_index <= r.idx;
    in_ch.centre_x <= r.cx; in_ch.centre_y <= r.cy; in_ch.centre_z <= r.cz;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_request(r);
    sent++;
  endtask

  // drop valid right after the last transfer, then wait for every result
  task automatic drain();
    in_ch.valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic point_req_t make_req(int i, int a, int b, int c);
    point_req_t r;
    r.idx = 16'(i); r.cx = a; r.cy = b; r.cz = c;
    return r;
  endfunction

  function automatic logic [31:0] rand_centre();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
    if (k < 8) return $urandom;
    return k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  function automatic int rand_frac();
    int k;
    k = $urandom_range(0, 5);
    if (k == 0) return 0;
    if (k == 1) return 32768;
    if (k == 2) return $urandom_range(32769, 65535);
    return $urandom_range(0, 32768);
  endfunction

  task automatic random_config();
    int cnt, rad, oa, ob, k;
    k = $urandom_range(0, 7);
    case (k)
      0: cnt = 1;
      1: cnt = 0;
      2: cnt = 65535;
      3: cnt = 2;
      4, 5: cnt = $urandom_range(3, 64);
      default: cnt = $urandom_range(2, 65535);
    endcase
    k = $urandom_range(0, 5);
    case (k)
      0: rad = 0;
      1: rad = 32'h7FFF_FFFF;
      2: rad = 65536;
      3: rad = $urandom & 32'h7FFF_FFFF;
      default: rad = $urandom_range(0, 32'h00FF_FFFF);
    endcase
    if ($urandom_range(0, 2) == 0) begin
      oa = 0; ob = 32768;
    end else begin
      oa = rand_frac(); ob = rand_frac();
    end
    set_config(cnt, rad, rand_frac(), rand_frac(), oa, ob);
  endtask

  initial begin
    point_req_t r;
    int phase_len, cnt;
    steady = 0; sink_wait = 0; quiet_cycles = 0; sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // defaults, then directed settings
    send_point(make_req(0, 0, 0, 0));
    send_point(make_req(65535, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_point(make_req(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    drain();
    set_config(5, 32'h7FFF_FFFF, 0, 32768, 8192, 24576);
    write_reg(REG_SPARE_A, 31'h7FFF_FFFF);
    write_reg(REG_SPARE_B, 31'd1);
    for (int i = 0; i < 5; i++) send_point(make_req(i, 0, 0, 0));
    send_point(make_req(10, 32'h7FFF_0000, -32'sh7FFF_0000, 32'h7FFF_FFFF));
    send_point(make_req(65535, 0, 0, 32'h8000_0000));
    drain();
    set_config(0, 65536, 30000, 2000, 24576, 4096);
    send_point(make_req(7, 123, -456, 789));
    drain();
    write_reg(REG_POINT_COUNT, 31'd9);
    send_point(make_req(0, 0, 0, 0));
    send_point(make_req(8, 0, 0, 0));
    send_point(make_req(40, 0, 0, 0));
    drain();
    set_config(65535, 0, 32768, 0, 32768, 0);
    send_point(make_req(65534, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    send_point(make_req(32767, 0, 0, 0));
    send_point(make_req(65535, 0, 0, 0));
    drain();

    while (sent < NUM_ITEMS) begin
      random_config();
      steady = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(80, 220);
      cnt = sb.count;
      for (int i = 0; i < phase_len && sent < NUM_ITEMS; i++) begin
        if (cnt > 1 && $urandom_range(0, 9) < 8)
          r.idx = 16'($urandom_range(0, cnt - 1));
        else
          r.idx = 16'($urandom);
        r.cx = rand_centre(); r.cy = rand_centre(); r.cz = rand_centre();
        send_point(r);
      end
      drain();
    end
    steady = 0;

    $display("Sent %0d point requests over many register settings; %0d results checked,",
             sent, sb.checked);
    $display("%0d of them flagged as clamped, %0d mismatches.", sb.clamp_seen, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
